// ===== design/hdbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hdbf_pkg;

    // Data widths of the fixed-point datapath.
    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int CFG_W    = 31;
    localparam int TINY_W   = 16;
    localparam int ORIENT_W = 18;
    localparam int RAND_W   = 16;

    // APB register file.
    localparam int ADDR_W = 5;
    localparam int APB_W  = 32;

    // Square root unit: one root bit per stage.
    localparam int SQRT_IN_W   = 64;
    localparam int SQRT_OUT_W  = 32;
    localparam int SQRT_REM_W  = SQRT_OUT_W + 2;
    localparam int SQRT_STAGES = SQRT_OUT_W;

    // Divider: quotient of a unit component never exceeds one in Q16.16.
    localparam int DIV_NUM_W  = 32;
    localparam int DIV_Q_W    = FRAC_W + 1;
    localparam int DIV_REM_W  = DIV_NUM_W + FRAC_W;
    localparam int DIV_STAGES = DIV_Q_W;

    // Pipeline depth.
    localparam int FRONT_STAGES = 2;
    localparam int POST_STAGES  = 4;
    localparam int FRONT_DEPTH  = FRONT_STAGES + SQRT_STAGES;
    localparam int LATENCY      = FRONT_DEPTH + DIV_STAGES + POST_STAGES;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_SPRING_K    = 3'd0,
        REG_BEND_K      = 3'd1,
        REG_REST_LENGTH = 3'd2,
        REG_CUTOFF      = 3'd3,
        REG_TINY        = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][DATA_W-1:0]   dabs;
        logic [2:0][RAND_W-1:0]   rabs;
        logic [2:0]               dneg;
        logic [2:0]               rneg;
        logic [2:0][ORIENT_W-1:0] orient;
    } t_front;

    typedef struct packed {
        logic [2:0]               dneg;
        logic [2:0]               rneg;
        logic [2:0][ORIENT_W-1:0] orient;
        logic [DATA_W-1:0]        adr;
        logic                     dr_pos;
        logic                     beyond;
        logic                     force_en;
        logic                     use_rand;
        logic                     torque_en;
    } t_mid;

endpackage
`default_nettype wire

// ===== design/hdbf_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hdbf_sqrt (
    input  wire logic                             i_clk,
    input  wire logic                             i_ce,
    input  wire logic [hdbf_pkg::SQRT_IN_W-1:0]  i_radicand,
    output logic      [hdbf_pkg::SQRT_OUT_W-1:0] o_root
);
    import hdbf_pkg::*;

    logic [SQRT_REM_W-1:0] r_rem  [SQRT_STAGES];
    logic [SQRT_OUT_W-1:0] r_root [SQRT_STAGES];
    logic [SQRT_IN_W-1:0]  r_rest [SQRT_STAGES];
    logic [SQRT_REM_W-1:0] n_rem  [SQRT_STAGES];
    logic [SQRT_OUT_W-1:0] n_root [SQRT_STAGES];
    logic [SQRT_IN_W-1:0]  n_rest [SQRT_STAGES];

    // Digit-by-digit root: each stage brings down two radicand bits.
    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic [SQRT_REM_W-1:0] rem_in;
        logic [SQRT_OUT_W-1:0] root_in;
        logic [SQRT_IN_W-1:0]  rest_in;
        logic [SQRT_REM_W+1:0] rem_sh;
        logic [SQRT_REM_W+1:0] trial;
        logic                  ge;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rest_in = i_radicand;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign rest_in = r_rest[s-1];
        end

        assign rem_sh = {rem_in, rest_in[SQRT_IN_W-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);
        assign n_rem[s]  = ge ? SQRT_REM_W'(rem_sh - trial) : rem_sh[SQRT_REM_W-1:0];
        assign n_root[s] = {root_in[SQRT_OUT_W-2:0], ge};
        assign n_rest[s] = {rest_in[SQRT_IN_W-3:0], 2'b00};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_rest[s] <= n_rest[s];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ===== design/hdbf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hdbf_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_ce,
    input  wire logic [hdbf_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [hdbf_pkg::DIV_NUM_W-1:0] i_den,
    output logic      [hdbf_pkg::DIV_Q_W-1:0]   o_quot
);
    import hdbf_pkg::*;

    logic [DIV_REM_W-1:0] r_rem  [DIV_STAGES];
    logic [DIV_NUM_W-1:0] r_den  [DIV_STAGES];
    logic [DIV_Q_W-1:0]   r_quot [DIV_STAGES];
    logic [DIV_REM_W-1:0] n_rem  [DIV_STAGES];
    logic [DIV_Q_W-1:0]   n_quot [DIV_STAGES];

    // Restoring division of num*2^16 by den, one quotient bit per stage,
    // most significant first. The quotient is known to fit DIV_Q_W bits.
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        localparam int K = DIV_Q_W - 1 - s;
        logic [DIV_REM_W-1:0] rem_in;
        logic [DIV_NUM_W-1:0] den_in;
        logic [DIV_Q_W-1:0]   quot_in;
        logic [DIV_REM_W:0]   den_sh;
        logic                 ge;

        if (s == 0) begin : g_first
            assign rem_in  = {i_num, {FRAC_W{1'b0}}};
            assign den_in  = i_den;
            assign quot_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign den_in  = r_den[s-1];
            assign quot_in = r_quot[s-1];
        end

        assign den_sh    = (DIV_REM_W+1)'(den_in) << K;
        assign ge        = ({1'b0, rem_in} >= den_sh);
        assign n_rem[s]  = ge ? DIV_REM_W'({1'b0, rem_in} - den_sh) : rem_in;
        assign n_quot[s] = {quot_in[DIV_Q_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[s]  <= n_rem[s];
                r_den[s]  <= den_in;
                r_quot[s] <= n_quot[s];
            end
        end
    end

    assign o_quot = r_quot[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== design/hdbf_post.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hdbf_post (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_ce,
    input  wire hdbf_pkg::t_mid                       i_mid,
    input  wire logic [2:0][hdbf_pkg::DIV_Q_W-1:0]   i_dq,
    input  wire logic [2:0][hdbf_pkg::DIV_Q_W-1:0]   i_rq,
    input  wire logic [hdbf_pkg::CFG_W-1:0]          i_spring_k,
    input  wire logic [hdbf_pkg::CFG_W-1:0]          i_bend_k,
    output logic      [2:0][hdbf_pkg::DATA_W-1:0]    o_force,
    output logic      [2:0][hdbf_pkg::DATA_W-1:0]    o_torque,
    output logic      [hdbf_pkg::DATA_W-1:0]         o_energy,
    output logic                                      o_beyond
);
    import hdbf_pkg::*;

    localparam int PROD_W = 2 * ORIENT_W;
    localparam int MAG_W  = CFG_W + DATA_W;
    localparam int CS_W   = PROD_W + 1 - FRAC_W;
    localparam int FP_W   = MAG_W - FRAC_W + DIV_Q_W;
    localparam int SQ_W   = 2 * DATA_W - FRAC_W;
    localparam int HALF_W = SQ_W / 2;
    localparam int EP_W   = CFG_W + HALF_W;
    localparam int ES_W   = EP_W + HALF_W - FRAC_W - 1;
    localparam int FM_W   = FP_W - FRAC_W;
    localparam int TQ_W   = CFG_W + 1 + CS_W;

    // Stage D: products of the unit separation with the orientation,
    // force magnitude and squared deviation.
    t_mid                             r_d_ctl;
    logic [2:0][DIV_Q_W-1:0]          r_d_umag, n_d_umag;
    logic [2:0]                       r_d_uneg, n_d_uneg;
    logic signed [PROD_W-1:0]         r_d_prod [6];
    logic signed [PROD_W-1:0]         n_d_prod [6];
    logic [MAG_W-1:0]                 r_d_mag, n_d_mag;
    logic [2*DATA_W-1:0]              r_d_sqe, n_d_sqe;
    logic signed [ORIENT_W-1:0]       w_dh [3];
    logic signed [ORIENT_W-1:0]       w_ov [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d_umag[i] = i_mid.use_rand ? i_rq[i] : i_dq[i];
            n_d_uneg[i] = i_mid.use_rand ? i_mid.rneg[i] : i_mid.dneg[i];
            w_dh[i] = i_mid.dneg[i] ? -$signed({1'b0, i_dq[i]}) : $signed({1'b0, i_dq[i]});
            w_ov[i] = $signed(i_mid.orient[i]);
        end
        n_d_prod[0] = w_dh[1] * w_ov[2];
        n_d_prod[1] = w_dh[2] * w_ov[1];
        n_d_prod[2] = w_dh[2] * w_ov[0];
        n_d_prod[3] = w_dh[0] * w_ov[2];
        n_d_prod[4] = w_dh[0] * w_ov[1];
        n_d_prod[5] = w_dh[1] * w_ov[0];
        n_d_mag = MAG_W'(i_spring_k) * MAG_W'(i_mid.adr);
        n_d_sqe = (2*DATA_W)'(i_mid.adr) * (2*DATA_W)'(i_mid.adr);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_d_ctl  <= i_mid;
            r_d_umag <= n_d_umag;
            r_d_uneg <= n_d_uneg;
            r_d_prod <= n_d_prod;
            r_d_mag  <= n_d_mag;
            r_d_sqe  <= n_d_sqe;
        end
    end

    // Stage E: scaled force components, cross product, energy partials.
    t_mid                         r_e_ctl;
    logic [2:0]                   r_e_uneg;
    logic [2:0][FP_W-1:0]         r_e_fp, n_e_fp;
    logic signed [CS_W-1:0]       r_e_cs [3];
    logic signed [CS_W-1:0]       n_e_cs [3];
    logic [EP_W-1:0]              r_e_elo, n_e_elo;
    logic [EP_W-1:0]              r_e_ehi, n_e_ehi;
    logic signed [PROD_W:0]       w_diff [3];
    logic [SQ_W-1:0]              w_sq;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e_fp[i] = FP_W'(r_d_mag[MAG_W-1:FRAC_W]) * FP_W'(r_d_umag[i]);
        end
        w_diff[0] = (PROD_W+1)'(r_d_prod[0]) - (PROD_W+1)'(r_d_prod[1]);
        w_diff[1] = (PROD_W+1)'(r_d_prod[2]) - (PROD_W+1)'(r_d_prod[3]);
        w_diff[2] = (PROD_W+1)'(r_d_prod[4]) - (PROD_W+1)'(r_d_prod[5]);
        for (int i = 0; i < 3; i++) begin
            n_e_cs[i] = CS_W'(w_diff[i] >>> FRAC_W);
        end
        w_sq    = r_d_sqe[2*DATA_W-1:FRAC_W];
        n_e_elo = EP_W'(i_spring_k) * EP_W'(w_sq[HALF_W-1:0]);
        n_e_ehi = EP_W'(i_spring_k) * EP_W'(w_sq[SQ_W-1:HALF_W]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_e_ctl  <= r_d_ctl;
            r_e_uneg <= r_d_uneg;
            r_e_fp   <= n_e_fp;
            r_e_cs   <= n_e_cs;
            r_e_elo  <= n_e_elo;
            r_e_ehi  <= n_e_ehi;
        end
    end

    // Stage F: force magnitudes, bend products, energy sum.
    t_mid                         r_f_ctl;
    logic [2:0]                   r_f_uneg;
    logic [2:0][FM_W-1:0]         r_f_fmag, n_f_fmag;
    logic signed [TQ_W-1:0]       r_f_tq [3];
    logic signed [TQ_W-1:0]       n_f_tq [3];
    logic [ES_W-1:0]              r_f_esh, n_f_esh;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_f_fmag[i] = r_e_fp[i][FP_W-1:FRAC_W];
            n_f_tq[i]   = $signed({1'b0, i_bend_k}) * r_e_cs[i];
        end
        n_f_esh = ES_W'(({r_e_ehi, {HALF_W{1'b0}}} + (EP_W+HALF_W)'(r_e_elo))
                        >> (FRAC_W + 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_f_ctl  <= r_e_ctl;
            r_f_uneg <= r_e_uneg;
            r_f_fmag <= n_f_fmag;
            r_f_tq   <= n_f_tq;
            r_f_esh  <= n_f_esh;
        end
    end

    // Stage G: sign, saturation and masking into the output register.
    logic [2:0][DATA_W-1:0]  n_force, n_torque;
    logic [DATA_W-1:0]       n_energy;
    logic signed [TQ_W-1:0]  w_tsh [3];
    logic                    w_fneg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_fneg = (r_f_ctl.dr_pos != r_f_uneg[i]);
            if (!r_f_ctl.force_en) begin
                n_force[i] = '0;
            end else if (!w_fneg) begin
                n_force[i] = (r_f_fmag[i] > FM_W'(SAT_MAX)) ? SAT_MAX
                                                             : r_f_fmag[i][DATA_W-1:0];
            end else begin
                n_force[i] = (r_f_fmag[i] > FM_W'(SAT_MIN)) ? SAT_MIN
                                                             : DATA_W'(0 - r_f_fmag[i]);
            end
            w_tsh[i] = r_f_tq[i] >>> FRAC_W;
            if (!r_f_ctl.torque_en) begin
                n_torque[i] = '0;
            end else if (w_tsh[i] > $signed(TQ_W'(SAT_MAX))) begin
                n_torque[i] = SAT_MAX;
            end else if (w_tsh[i] < -$signed(TQ_W'(SAT_MIN))) begin
                n_torque[i] = SAT_MIN;
            end else begin
                n_torque[i] = w_tsh[i][DATA_W-1:0];
            end
        end
        if (r_f_ctl.beyond) begin
            n_energy = '0;
        end else begin
            n_energy = (r_f_esh > ES_W'(SAT_MAX)) ? SAT_MAX : r_f_esh[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_force  <= n_force;
            o_torque <= n_torque;
            o_energy <= n_energy;
            o_beyond <= r_f_ctl.beyond;
        end
    end

endmodule
`default_nettype wire

// ===== design/harmonic_dumbbell_bond_force_top.sv =====
// Throughput: one item per cycle; the whole pipeline holds while the output
// item waits, and the 32-stage square root and 17-stage dividers set the depth.
// Reset (synchronous, active low) clears the valid bits and loads the
// registers: all zero except tiny_threshold, which becomes 1.
`timescale 1ns / 1ps
`default_nettype none
module harmonic_dumbbell_bond_force_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [31:0]                   i_sep_x,
    input  wire logic [31:0]                   i_sep_y,
    input  wire logic [31:0]                   i_sep_z,
    input  wire logic [17:0]                   i_orient_x,
    input  wire logic [17:0]                   i_orient_y,
    input  wire logic [17:0]                   i_orient_z,
    input  wire logic [15:0]                   i_rand_x,
    input  wire logic [15:0]                   i_rand_y,
    input  wire logic [15:0]                   i_rand_z,
    // Output channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [31:0]                        o_force_x,
    output logic [31:0]                        o_force_y,
    output logic [31:0]                        o_force_z,
    output logic [31:0]                        o_torque_x,
    output logic [31:0]                        o_torque_y,
    output logic [31:0]                        o_torque_z,
    output logic [31:0]                        o_energy,
    output logic                               o_beyond_cutoff,
    // Register port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hdbf_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [hdbf_pkg::APB_W-1:0]   pwdata,
    output logic      [hdbf_pkg::APB_W-1:0]   prdata,
    output logic                               pready
);
    import hdbf_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the access phase; the
    // port never waits. The user must write only while the pipeline is
    // empty; the block does not enforce it. Every stage reads them directly.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  r_spring_k;
    logic [CFG_W-1:0]  r_bend_k;
    logic [CFG_W-1:0]  r_rest_length;
    logic [CFG_W-1:0]  r_cutoff;
    logic [TINY_W-1:0] r_tiny;
    t_reg_idx          w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring_k    <= '0;
            r_bend_k      <= '0;
            r_rest_length <= '0;
            r_cutoff      <= '0;
            r_tiny        <= TINY_W'(1);
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg_idx)
                REG_SPRING_K:    r_spring_k    <= pwdata[CFG_W-1:0];
                REG_BEND_K:      r_bend_k      <= pwdata[CFG_W-1:0];
                REG_REST_LENGTH: r_rest_length <= pwdata[CFG_W-1:0];
                REG_CUTOFF:      r_cutoff      <= pwdata[CFG_W-1:0];
                REG_TINY:        r_tiny        <= pwdata[TINY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_SPRING_K:    prdata = APB_W'(r_spring_k);
            REG_BEND_K:      prdata = APB_W'(r_bend_k);
            REG_REST_LENGTH: prdata = APB_W'(r_rest_length);
            REG_CUTOFF:      prdata = APB_W'(r_cutoff);
            REG_TINY:        prdata = APB_W'(r_tiny);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control. All stages share one enable: the pipeline moves
    // whenever the output register is empty or its item is being taken.
    // Valid bits run alongside the data, so bubbles simply flow through.
    // ------------------------------------------------------------------
    logic               w_ce;
    logic [LATENCY-1:0] r_vld;

    assign w_ce        = !r_vld[LATENCY-1] || i_out_ready;
    assign o_in_ready  = w_ce;
    assign o_out_valid = r_vld[LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LATENCY-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Front end: magnitudes and squares of the separation and the random
    // vector (stage 1), then the sums of squares (stage 2). The squared
    // separation is exact and fits 64 bits.
    // ------------------------------------------------------------------
    t_front                   n_front;
    t_front                   r_front [FRONT_DEPTH];
    logic [2:0][DATA_W-1:0]   w_sep;
    logic [2:0][RAND_W-1:0]   w_rand;
    logic [2:0][2*DATA_W-1:0] r_sqd, n_sqd;
    logic [2:0][2*RAND_W-1:0] r_sqr, n_sqr;
    logic [2*DATA_W-1:0]      r_sumd, n_sumd;
    logic [2*RAND_W-1:0]      r_sumr, n_sumr;

    assign w_sep  = {i_sep_z, i_sep_y, i_sep_x};
    assign w_rand = {i_rand_z, i_rand_y, i_rand_x};

    always_comb begin
        n_front.orient = {i_orient_z, i_orient_y, i_orient_x};
        for (int i = 0; i < 3; i++) begin
            n_front.dneg[i] = w_sep[i][DATA_W-1];
            n_front.rneg[i] = w_rand[i][RAND_W-1];
            n_front.dabs[i] = n_front.dneg[i] ? DATA_W'(0 - w_sep[i]) : w_sep[i];
            n_front.rabs[i] = n_front.rneg[i] ? RAND_W'(0 - w_rand[i]) : w_rand[i];
            n_sqd[i] = (2*DATA_W)'(n_front.dabs[i]) * (2*DATA_W)'(n_front.dabs[i]);
            n_sqr[i] = (2*RAND_W)'(n_front.rabs[i]) * (2*RAND_W)'(n_front.rabs[i]);
        end
        n_sumd = r_sqd[0] + r_sqd[1] + r_sqd[2];
        n_sumr = r_sqr[0] + r_sqr[1] + r_sqr[2];
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_front[0] <= n_front;
            for (int k = 1; k < FRONT_DEPTH; k++) begin
                r_front[k] <= r_front[k-1];
            end
            r_sqd  <= n_sqd;
            r_sqr  <= n_sqr;
            r_sumd <= n_sumd;
            r_sumr <= n_sumr;
        end
    end

    // ------------------------------------------------------------------
    // Square roots: the distance and the length of the random vector run
    // through identical units so that both arrive in the same cycle.
    // ------------------------------------------------------------------
    logic [SQRT_OUT_W-1:0] w_dist;
    logic [SQRT_OUT_W-1:0] w_rlen;

    hdbf_sqrt u_sqrt_dist (
        .i_clk      (i_clk),
        .i_ce       (w_ce),
        .i_radicand (r_sumd),
        .o_root     (w_dist)
    );

    hdbf_sqrt u_sqrt_rand (
        .i_clk      (i_clk),
        .i_ce       (w_ce),
        .i_radicand (SQRT_IN_W'(r_sumr)),
        .o_root     (w_rlen)
    );

    // ------------------------------------------------------------------
    // Decisions taken once the distance is known: cutoff, deviation from
    // the rest length, and which of the special cases applies. A zero
    // distance zeroes the torque; a tiny distance takes the force direction
    // from the random vector, and a zero random vector drops the force.
    // ------------------------------------------------------------------
    t_front            w_fr;
    t_mid              n_mid;
    t_mid              r_mid [DIV_STAGES];
    logic [DATA_W-1:0] w_rest;
    logic [DATA_W-1:0] w_tiny;
    logic              w_dist_big;

    assign w_fr   = r_front[FRONT_DEPTH-1];
    assign w_rest = DATA_W'(r_rest_length);
    assign w_tiny = DATA_W'(r_tiny);

    always_comb begin
        n_mid.dneg      = w_fr.dneg;
        n_mid.rneg      = w_fr.rneg;
        n_mid.orient    = w_fr.orient;
        n_mid.beyond    = (r_cutoff != '0) && (w_dist > DATA_W'(r_cutoff));
        n_mid.dr_pos    = (w_dist > w_rest);
        n_mid.adr       = n_mid.dr_pos ? (w_dist - w_rest) : (w_rest - w_dist);
        w_dist_big      = (w_dist > w_tiny);
        n_mid.use_rand  = !w_dist_big;
        n_mid.force_en  = !n_mid.beyond && (n_mid.adr > w_tiny)
                          && (w_dist_big || (w_rlen != '0));
        n_mid.torque_en = !n_mid.beyond && (w_dist != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_mid[0] <= n_mid;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_mid[k] <= r_mid[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Unit vectors: six dividers in parallel, three for the separation and
    // three for the random vector. A zero divisor gives a meaningless
    // quotient, which the flags above mask out.
    // ------------------------------------------------------------------
    logic [2:0][DIV_Q_W-1:0] w_dq;
    logic [2:0][DIV_Q_W-1:0] w_rq;

    for (genvar i = 0; i < 3; i++) begin : g_div
        hdbf_div u_div_sep (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_num  (w_fr.dabs[i]),
            .i_den  (w_dist),
            .o_quot (w_dq[i])
        );

        hdbf_div u_div_rand (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_num  (DIV_NUM_W'(w_fr.rabs[i])),
            .i_den  (w_rlen),
            .o_quot (w_rq[i])
        );
    end

    // ------------------------------------------------------------------
    // Back end: force, torque and energy, ending in the output register.
    // ------------------------------------------------------------------
    logic [2:0][DATA_W-1:0] w_force;
    logic [2:0][DATA_W-1:0] w_torque;

    hdbf_post u_post (
        .i_clk      (i_clk),
        .i_ce       (w_ce),
        .i_mid      (r_mid[DIV_STAGES-1]),
        .i_dq       (w_dq),
        .i_rq       (w_rq),
        .i_spring_k (r_spring_k),
        .i_bend_k   (r_bend_k),
        .o_force    (w_force),
        .o_torque   (w_torque),
        .o_energy   (o_energy),
        .o_beyond   (o_beyond_cutoff)
    );

    assign o_force_x  = w_force[0];
    assign o_force_y  = w_force[1];
    assign o_force_z  = w_force[2];
    assign o_torque_x = w_torque[0];
    assign o_torque_y = w_torque[1];
    assign o_torque_z = w_torque[2];

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_beyond_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_beyond_cutoff |->
            (w_force == '0) && (w_torque == '0) && (o_energy == '0))
        else $error("beyond-cutoff item carries nonzero results");

    a_energy_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_energy[DATA_W-1])
        else $error("bond energy came out negative");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ce |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

endmodule
`default_nettype wire
